// ===== sv/wps_pkg.sv =====
package wps_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DEF_MAX_WAYPOINTS = 64;
    localparam int DEF_CORDIC_STEPS  = 16;

    // Fixed sizes of the arithmetic.
    localparam int ITER_W     = 5;
    localparam int SQRT_STEPS = 32;

    // Item modes.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_BEGIN   = 2'd1;
    localparam logic [1:0] MODE_ADVANCE = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [31:0]        step_distance;
    } wps_in_t;

    // Result beat.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [5:0]         segment_index;
        logic               route_done;
        logic               error;
    } wps_out_t;

    // Waypoint store read selection.
    typedef enum logic [2:0] {
        RD_NONE,
        RD_ZERO,
        RD_ONE,
        RD_TARGET,
        RD_NEXT
    } wps_rd_t;

    // Datapath operations, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_WP,
        OP_BEGIN_A,
        OP_DIR_INIT,
        OP_VEC_STEP,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_DIR_FIN,
        OP_SEG_LATCH,
        OP_SQ_A,
        OP_SQ_B,
        OP_SQ_SUM,
        OP_SQRT_STEP,
        OP_CORNER_LAST,
        OP_CORNER_NEXT,
        OP_MUL_X,
        OP_ADD_X,
        OP_ADD_Y,
        OP_DONE_CHECK
    } wps_op_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BEGIN0,
        ST_DIR_INIT,
        ST_VEC,
        ST_ROT_INIT,
        ST_ROT,
        ST_DIR_FIN,
        ST_SEG,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_SUM,
        ST_SQRT,
        ST_CMP,
        ST_MUL_X,
        ST_ADD_X,
        ST_ADD_Y,
        ST_CHECK,
        ST_CHECK_CMP,
        ST_OUT
    } wps_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;
        logic    mem_wr;
        wps_rd_t rd;
        wps_op_t op;
        logic    set_err;
        logic    out_load;
    } wps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] mode;
        logic       store_full;
        logic       few_points;
        logic       step_bad;
        logic       sum_ovf;
        logic       dist_gt_len;
        logic       last_seg;
        logic       dir_zero;
        logic       cordic_last;
        logic       sqrt_last;
        logic       check_needed;
    } wps_sts_t;

    // Arctangent of 2^-i as a binary angle, where 2^32 is a full turn.
    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            5'd30:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/wps_ctrl.sv =====
module wps_ctrl
    import wps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    output logic     result_valid,
    input  logic     result_stall,
    output wps_cmd_t cmd,
    input  wps_sts_t sts
);

    wps_state_t state_reg;
    wps_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    wps_state_t dir_ret;

    // The result slot is free when empty or when its beat leaves now.
    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

    // After a direction is found, a begin item finishes and a step moves on.
    assign dir_ret = (sts.mode == MODE_BEGIN) ? ST_CHECK : ST_MUL_X;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (sts.mode == MODE_BEGIN && !sts.few_points)
                begin
                    state_next = ST_BEGIN0;
                end
                else if (sts.mode == MODE_ADVANCE && !sts.step_bad)
                begin
                    state_next = ST_SEG;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_BEGIN0:    state_next = ST_DIR_INIT;
            ST_DIR_INIT:  state_next = sts.dir_zero ? dir_ret : ST_VEC;
            ST_VEC:       state_next = sts.cordic_last ? ST_ROT_INIT : ST_VEC;
            ST_ROT_INIT:  state_next = ST_ROT;
            ST_ROT:       state_next = sts.cordic_last ? ST_DIR_FIN : ST_ROT;
            ST_DIR_FIN:   state_next = dir_ret;
            ST_SEG:       state_next = ST_SQ_A;
            ST_SQ_A:      state_next = ST_SQ_B;
            ST_SQ_B:      state_next = ST_SQ_SUM;
            ST_SQ_SUM:    state_next = ST_SQRT;
            ST_SQRT:
            begin
                priority if (sts.sum_ovf)
                begin
                    state_next = ST_MUL_X;
                end
                else if (sts.sqrt_last)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_CMP:
            begin
                if (sts.dist_gt_len && !sts.last_seg)
                begin
                    state_next = ST_DIR_INIT;
                end
                else
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:     state_next = ST_ADD_X;
            ST_ADD_X:     state_next = ST_ADD_Y;
            ST_ADD_Y:     state_next = ST_CHECK;
            ST_CHECK:     state_next = sts.check_needed ? ST_CHECK_CMP : ST_OUT;
            ST_CHECK_CMP: state_next = ST_OUT;
            ST_OUT:       state_next = out_free ? ST_IDLE : ST_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb
    begin
        cmd          = '0;
        cmd.rd       = RD_NONE;
        cmd.op       = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_in = item_valid;
            end
            ST_DECODE:
            begin
                unique case (sts.mode)
                    MODE_LOAD:
                    begin
                        if (sts.store_full)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.mem_wr = 1'b1;
                            cmd.op     = OP_LOAD_WP;
                        end
                    end
                    MODE_BEGIN:
                    begin
                        if (sts.few_points)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.rd = RD_ZERO;
                        end
                    end
                    MODE_ADVANCE:
                    begin
                        if (sts.step_bad)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.rd = RD_TARGET;
                        end
                    end
                    default:
                    begin
                        cmd.set_err = 1'b1;
                    end
                endcase
            end
            ST_BEGIN0:
            begin
                cmd.op = OP_BEGIN_A;
                cmd.rd = RD_ONE;
            end
            ST_DIR_INIT:  cmd.op = OP_DIR_INIT;
            ST_VEC:       cmd.op = OP_VEC_STEP;
            ST_ROT_INIT:  cmd.op = OP_ROT_INIT;
            ST_ROT:       cmd.op = OP_ROT_STEP;
            ST_DIR_FIN:   cmd.op = OP_DIR_FIN;
            ST_SEG:       cmd.op = OP_SEG_LATCH;
            ST_SQ_A:      cmd.op = OP_SQ_A;
            ST_SQ_B:      cmd.op = OP_SQ_B;
            ST_SQ_SUM:    cmd.op = OP_SQ_SUM;
            ST_SQRT:
            begin
                if (!sts.sum_ovf)
                begin
                    cmd.op = OP_SQRT_STEP;
                end
            end
            ST_CMP:
            begin
                if (sts.dist_gt_len)
                begin
                    if (sts.last_seg)
                    begin
                        cmd.op = OP_CORNER_LAST;
                    end
                    else
                    begin
                        cmd.op = OP_CORNER_NEXT;
                        cmd.rd = RD_NEXT;
                    end
                end
            end
            ST_MUL_X:     cmd.op = OP_MUL_X;
            ST_ADD_X:     cmd.op = OP_ADD_X;
            ST_ADD_Y:     cmd.op = OP_ADD_Y;
            ST_CHECK:
            begin
                if (sts.check_needed)
                begin
                    cmd.rd = RD_TARGET;
                end
            end
            ST_CHECK_CMP: cmd.op = OP_DONE_CHECK;
            ST_OUT:       cmd.out_load = out_free;
            default:      cmd.op = OP_NONE;
        endcase
    end

    // Result slot occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/wps_datapath.sv =====
module wps_datapath
    import wps_pkg::*;
#(
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS,
    parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  wps_cmd_t cmd,
    output wps_sts_t sts,
    input  wps_in_t  item,
    output wps_out_t result
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;
    localparam logic signed [31:0] QUARTER     = 32'sd1073741824;
    localparam logic signed [17:0] ONE_Q16     = 18'sd65536;
    localparam logic [31:0]        HALF_TURN   = 32'h8000_0000;

    // Waypoint store, x in the upper half and y in the lower half.
    logic [63:0]        wp_mem [MAX_WAYPOINTS];
    logic [63:0]        rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    // Architectural state.
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      target_reg;
    logic               active_reg;
    logic signed [31:0] cur_x_reg;
    logic signed [31:0] cur_y_reg;
    logic signed [17:0] cos_reg;
    logic signed [17:0] sin_reg;

    // Item and working registers.
    logic [1:0]         mode_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic [31:0]        dist_reg;
    logic               err_reg;
    logic               done_reg;
    logic signed [31:0] anc_x_reg;
    logic signed [31:0] anc_y_reg;
    logic [31:0]        dxa_reg;
    logic [31:0]        dya_reg;
    logic signed [65:0] prod_reg;
    logic [64:0]        sum_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic [31:0]        vz_reg;
    logic signed [33:0] rz_reg;
    logic               neg_reg;
    logic [ITER_W-1:0]  iter_reg;
    wps_out_t           out_reg;

    logic signed [31:0] rd_x;
    logic signed [31:0] rd_y;
    logic [CW-1:0]      tgt_ext;
    logic [CW-1:0]      tgt_inc;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic signed [35:0] cx_sh;
    logic signed [35:0] cy_sh;
    logic [31:0]        atan_val;
    logic signed [31:0] vz_s;
    logic [63:0]        trial;
    logic signed [34:0] c_fin;
    logic signed [34:0] s_fin;

    assign rd_x = rd_data_reg[63:32];
    assign rd_y = rd_data_reg[31:0];

    assign tgt_ext = CW'(target_reg);
    assign tgt_inc = tgt_ext + CW'(1);

    // Status for the controller.
    assign sts.mode         = mode_reg;
    assign sts.store_full   = (count_reg >= CW'(MAX_WAYPOINTS));
    assign sts.few_points   = (count_reg < CW'(2));
    assign sts.step_bad     = !active_reg || (tgt_ext >= count_reg);
    assign sts.sum_ovf      = sum_reg[64];
    assign sts.dist_gt_len  = (dist_reg > root_reg[31:0]);
    assign sts.last_seg     = (tgt_inc >= count_reg);
    assign sts.dir_zero     = (vx == 33'sd0) && (vy == 33'sd0);
    assign sts.cordic_last  = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign sts.sqrt_last    = (iter_reg == ITER_W'(SQRT_STEPS - 1));
    assign sts.check_needed = active_reg && (tgt_ext < count_reg) && (tgt_inc == count_reg);

    assign result = out_reg;

    // Rounds a Q2.30 value to Q2.16 and clamps it to plus or minus one.
    function automatic logic signed [17:0] to_q16(input logic signed [34:0] v);
        logic signed [34:0] r;
        logic signed [17:0] q;
        r = (v + 35'sd8192) >>> 14;
        if (r > 35'sd65536)
        begin
            q = ONE_Q16;
        end
        else if (r < -35'sd65536)
        begin
            q = -ONE_Q16;
        end
        else
        begin
            q = r[17:0];
        end
        return q;
    endfunction

    // Adds a rounded move component to a coordinate and saturates.
    function automatic logic signed [31:0] move(input logic signed [31:0] pos,
                                                input logic signed [65:0] p);
        logic signed [65:0] stp;
        logic signed [66:0] s;
        logic signed [31:0] q;
        stp = (p + 66'sd32768) >>> 16;
        s   = 67'(pos) + 67'(stp);
        if (s > 67'sd2147483647)
        begin
            q = 32'sh7FFF_FFFF;
        end
        else if (s < -67'sd2147483648)
        begin
            q = 32'sh8000_0000;
        end
        else
        begin
            q = s[31:0];
        end
        return q;
    endfunction

    // Read address selection.
    always_comb
    begin
        rd_en = 1'b1;
        unique case (cmd.rd)
            RD_ZERO:   rd_addr = '0;
            RD_ONE:    rd_addr = AW'(1);
            RD_TARGET: rd_addr = target_reg;
            RD_NEXT:   rd_addr = target_reg + AW'(1);
            default:
            begin
                rd_addr = '0;
                rd_en   = 1'b0;
            end
        endcase
    end

    // Waypoint store.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            wp_mem[count_reg[AW-1:0]] <= {px_reg, py_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= wp_mem[rd_addr];
        end
    end

    // Segment vector from the anchor waypoint to the one just read, and from the current position to it.
    assign vx = 33'(rd_x) - 33'(anc_x_reg);
    assign vy = 33'(rd_y) - 33'(anc_y_reg);
    assign sx = 33'(rd_x) - 33'(cur_x_reg);
    assign sy = 33'(rd_y) - 33'(cur_y_reg);

    // Shared multiplier for the squares and the move components.
    always_comb
    begin
        unique case (cmd.op)
            OP_SQ_A:
            begin
                mul_a = {1'b0, dxa_reg};
                mul_b = {1'b0, dxa_reg};
            end
            OP_SQ_B:
            begin
                mul_a = {1'b0, dya_reg};
                mul_b = {1'b0, dya_reg};
            end
            OP_MUL_X:
            begin
                mul_a = {1'b0, dist_reg};
                mul_b = 33'(cos_reg);
            end
            OP_ADD_X:
            begin
                mul_a = {1'b0, dist_reg};
                mul_b = 33'(sin_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // CORDIC shifts, angle table, square root trial value and the sign-folded CORDIC results.
    assign cx_sh    = cx_reg >>> iter_reg;
    assign cy_sh    = cy_reg >>> iter_reg;
    assign atan_val = atan_entry(iter_reg);
    assign vz_s     = vz_reg;
    assign trial    = root_reg + bit_reg;
    assign c_fin    = neg_reg ? -$signed(cx_reg[34:0]) : $signed(cx_reg[34:0]);
    assign s_fin    = neg_reg ? -$signed(cy_reg[34:0]) : $signed(cy_reg[34:0]);

    // State that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            target_reg <= '0;
            active_reg <= 1'b0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            cos_reg    <= '0;
            sin_reg    <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD_WP:
                begin
                    count_reg <= count_reg + CW'(1);
                end
                OP_BEGIN_A:
                begin
                    cur_x_reg  <= rd_x;
                    cur_y_reg  <= rd_y;
                    target_reg <= AW'(1);
                    active_reg <= 1'b1;
                end
                OP_DIR_INIT:
                begin
                    if (sts.dir_zero)
                    begin
                        cos_reg <= ONE_Q16;
                        sin_reg <= '0;
                    end
                end
                OP_DIR_FIN:
                begin
                    cos_reg <= to_q16(c_fin);
                    sin_reg <= to_q16(s_fin);
                end
                OP_CORNER_LAST:
                begin
                    cur_x_reg <= anc_x_reg;
                    cur_y_reg <= anc_y_reg;
                end
                OP_CORNER_NEXT:
                begin
                    cur_x_reg  <= anc_x_reg;
                    cur_y_reg  <= anc_y_reg;
                    target_reg <= target_reg + AW'(1);
                end
                OP_ADD_X:
                begin
                    cur_x_reg <= move(cur_x_reg, prod_reg);
                end
                OP_ADD_Y:
                begin
                    cur_y_reg <= move(cur_y_reg, prod_reg);
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (cmd.latch_in)
        begin
            mode_reg <= item.mode;
            px_reg   <= item.point_x;
            py_reg   <= item.point_y;
            dist_reg <= item.step_distance;
            err_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        if (cmd.set_err)
        begin
            err_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_reg.pos_x         <= cur_x_reg;
            out_reg.pos_y         <= cur_y_reg;
            out_reg.segment_index <= 6'(target_reg);
            out_reg.route_done    <= done_reg;
            out_reg.error         <= err_reg;
        end
        unique case (cmd.op)
            OP_BEGIN_A:
            begin
                anc_x_reg <= rd_x;
                anc_y_reg <= rd_y;
            end
            OP_SEG_LATCH:
            begin
                anc_x_reg <= rd_x;
                anc_y_reg <= rd_y;
                dxa_reg   <= sx[32] ? 32'(-sx) : sx[31:0];
                dya_reg   <= sy[32] ? 32'(-sy) : sy[31:0];
            end
            OP_DIR_INIT:
            begin
                iter_reg <= '0;
                if (vx[32])
                begin
                    cx_reg <= -36'(vx);
                    cy_reg <= -36'(vy);
                    vz_reg <= HALF_TURN;
                end
                else
                begin
                    cx_reg <= 36'(vx);
                    cy_reg <= 36'(vy);
                    vz_reg <= '0;
                end
            end
            OP_VEC_STEP:
            begin
                iter_reg <= iter_reg + ITER_W'(1);
                if (!cy_reg[35])
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    vz_reg <= vz_reg + atan_val;
                end
                else
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    vz_reg <= vz_reg - atan_val;
                end
            end
            OP_ROT_INIT:
            begin
                // Fold angles beyond a quarter turn into the right half plane.
                iter_reg <= '0;
                cx_reg   <= 36'(INV_GAIN);
                cy_reg   <= '0;
                if (vz_s > QUARTER)
                begin
                    rz_reg  <= 34'(vz_s) - 34'sd2147483648;
                    neg_reg <= 1'b1;
                end
                else if (vz_s < -QUARTER)
                begin
                    rz_reg  <= 34'(vz_s) + 34'sd2147483648;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    rz_reg  <= 34'(vz_s);
                    neg_reg <= 1'b0;
                end
            end
            OP_ROT_STEP:
            begin
                iter_reg <= iter_reg + ITER_W'(1);
                if (!rz_reg[33])
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    rz_reg <= rz_reg - 34'(atan_val);
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    rz_reg <= rz_reg + 34'(atan_val);
                end
            end
            OP_SQ_B:
            begin
                sum_reg <= {1'b0, prod_reg[63:0]};
            end
            OP_SQ_SUM:
            begin
                sum_reg  <= {1'b0, sum_reg[63:0]} + {1'b0, prod_reg[63:0]};
                root_reg <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
                iter_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                // One result bit per cycle, restoring method.
                iter_reg <= iter_reg + ITER_W'(1);
                bit_reg  <= bit_reg >> 2;
                if (sum_reg[63:0] >= trial)
                begin
                    sum_reg[63:0] <= sum_reg[63:0] - trial;
                    root_reg      <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            OP_CORNER_LAST:
            begin
                dist_reg <= '0;
            end
            OP_CORNER_NEXT:
            begin
                dist_reg <= dist_reg - root_reg[31:0];
            end
            OP_DONE_CHECK:
            begin
                done_reg <= (cur_x_reg == rd_x) && (cur_y_reg == rd_y);
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

endmodule

// ===== sv/waypoint_path_stepper.sv =====
// Waypoint path stepper: each input beat loads a waypoint (mode 0), starts the
// route at waypoint 0 heading for waypoint 1 (mode 1) or moves the position a
// distance along the polyline (mode 2), crossing at most one corner per beat,
// and each gives exactly one result beat with the position, the target
// waypoint, a done flag and an error flag. Items are handled one at a time.
// A begin runs the CORDIC vectoring and rotation loops to find the heading; a
// step runs the bit-serial square root of the remaining segment length and,
// when it turns a corner, the CORDIC vectoring and rotation loops as well. A
// new item is taken while the previous result still waits in the output
// register.
module waypoint_path_stepper
    import wps_pkg::*;
#(
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS,
    parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  wps_in_t  item,
    output logic     result_valid,
    input  logic     result_stall,
    output wps_out_t result
);

    wps_cmd_t cmd;
    wps_sts_t sts;

    // Sequencer.
    wps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    // Waypoint store and arithmetic.
    wps_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result)
    );

endmodule
